[src/lirs_pkg.sv]
// Package: shared types and constants for the linear interpolation resampler.
package lirs_pkg;

  localparam int MaxKnots = 1024;
  localparam int IdxW     = $clog2(MaxKnots);
  localparam int CntW     = IdxW + 1;
  localparam int DataW    = 32;
  localparam int QuoW     = 32;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_CHECK, S_FETCH, S_DIFF, S_MUL_A, S_MUL_B,
    S_SUM, S_DIV_INIT, S_DIV, S_DONE
  } lirs_state_t;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic wr_knot;
    logic ld_query;
    logic next_io;
    logic take_hit;
    logic take_miss;
    logic capture;
    logic mul_a;
    logic mul_b;
    logic sum;
    logic div_init;
    logic div_step;
    logic out_load;
  } lirs_cmd_t;

  typedef struct packed {
    logic hit;
    logic at_last;
    logic out_busy;
  } lirs_stat_t;

endpackage

[src/lirs_if.sv]
// Interfaces: request and response channels of the resampler.
interface lirs_req_if;
  import lirs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [IdxW-1:0]         knot_index;
  logic signed [DataW-1:0] knot_value;
  logic signed [DataW-1:0] position;
  logic                    new_sweep;
  modport source (output valid, func, knot_index, knot_value, position, new_sweep,
                  input ready);
  modport sink   (input valid, func, knot_index, knot_value, position, new_sweep,
                  output ready);
endinterface

interface lirs_rsp_if;
  import lirs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] interp_value;
  logic [IdxW-1:0]         segment_used;
  logic                    out_of_range;
  logic                    zero_width;
  modport source (output valid, interp_value, segment_used, out_of_range, zero_width,
                  input ready);
  modport sink   (input valid, interp_value, segment_used, out_of_range, zero_width,
                  output ready);
endinterface

[src/lirs_ctrl.sv]
// Controller: takes knot writes and sequences search, multiply and division for each query.
module lirs_ctrl
  import lirs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_func,
  output logic       req_ready,
  input  lirs_stat_t stat,
  output lirs_cmd_t  cmd
);

  lirs_state_t state, state_next;
  logic [4:0]  step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_func == FUNC_WRITE) begin
            cmd.wr_knot = 1'b1;
          end else begin
            cmd.ld_query = 1'b1;
            state_next   = S_READ;
          end
        end
      end
      S_READ:  state_next = S_CHECK;
      S_CHECK: begin
        if (stat.hit) begin
          cmd.take_hit = 1'b1;
          state_next   = S_FETCH;
        end else if (stat.at_last) begin
          cmd.take_miss = 1'b1;
          state_next    = S_FETCH;
        end else begin
          cmd.next_io = 1'b1;
          state_next  = S_READ;
        end
      end
      S_FETCH: state_next = S_DIFF;
      S_DIFF: begin
        cmd.capture = 1'b1;
        state_next  = S_MUL_A;
      end
      S_MUL_A: begin
        cmd.mul_a  = 1'b1;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_b  = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        step_next    = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 5'd1;
        if (step == 5'(QuoW - 1)) state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[src/lirs_dp.sv]
// Datapath: knot tables, segment search registers, multiplier, divider, result register.
module lirs_dp
  import lirs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  lirs_cmd_t               cmd,
  output lirs_stat_t              stat,
  input  logic [CntW-1:0]         knot_count,
  input  logic [IdxW-1:0]         in_index,
  input  logic signed [DataW-1:0] in_value,
  input  logic signed [DataW-1:0] in_position,
  input  logic                    in_new_sweep,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [DataW-1:0] out_value,
  output logic [IdxW-1:0]         out_segment,
  output logic                    out_oor,
  output logic                    out_zw
);

  logic [DataW-1:0] pos_mem [MaxKnots];
  logic [DataW-1:0] val_mem [MaxKnots];
  logic signed [DataW-1:0] rd_plo, rd_phi, rd_ylo, rd_yhi;

  logic [IdxW-1:0] io, start, search_start, last;
  logic [CntW-1:0] cnt;
  logic            found;
  logic signed [DataW-1:0] qpos, ylo, yhi;
  logic signed [DataW:0]   dxlo, dxhi, width;
  logic signed [2*DataW:0] prod_a, prod_b, mul_res;
  logic signed [2*DataW+1:0] num;
  logic [2*DataW+1:0] num_mag;
  logic [DataW:0]    mag_hi;
  logic [DataW:0]    dvs, rem;
  logic [DataW+1:0]  rem_sh;
  logic [QuoW-1:0]   low, quo;
  logic              neg, big;
  logic [IdxW-1:0]   ss_sel;
  logic signed [DataW-1:0] mul_x;
  logic signed [DataW:0]   mul_y;
  logic signed [DataW-1:0] res;

  always_comb begin
    if (knot_count < CntW'(2))             cnt = CntW'(2);
    else if (knot_count > CntW'(MaxKnots)) cnt = CntW'(MaxKnots);
    else                                   cnt = knot_count;
    last   = IdxW'(cnt - CntW'(2));
    ss_sel = in_new_sweep ? '0 : search_start;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_knot) begin
      pos_mem[in_index] <= in_position;
      val_mem[in_index] <= in_value;
    end
    rd_plo <= pos_mem[io];
    rd_phi <= pos_mem[io + IdxW'(1)];
    rd_ylo <= val_mem[io];
    rd_yhi <= val_mem[io + IdxW'(1)];
  end

  assign stat.hit      = (qpos <= rd_phi) && (qpos >= rd_plo);
  assign stat.at_last  = (io == last);
  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_start <= '0;
    end else if (cmd.take_hit) begin
      search_start <= io;
    end else if (cmd.take_miss) begin
      search_start <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_query) begin
      qpos  <= in_position;
      start <= (ss_sel > last) ? last : ss_sel;
      io    <= (ss_sel > last) ? last : ss_sel;
    end
    if (cmd.next_io) io <= io + IdxW'(1);
    if (cmd.take_hit) found <= 1'b1;
    if (cmd.take_miss) begin
      found <= 1'b0;
      io    <= start;
    end
  end

  assign mul_x   = cmd.mul_a ? ylo : yhi;
  assign mul_y   = cmd.mul_a ? dxhi : dxlo;
  assign mul_res = mul_x * mul_y;
  assign rem_sh  = {rem, low[QuoW-1]};
  assign num_mag = num[2*DataW+1] ? -num : num;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ylo   <= rd_ylo;
      yhi   <= rd_yhi;
      dxlo  <= (DataW+1)'(qpos) - (DataW+1)'(rd_plo);
      dxhi  <= (DataW+1)'(rd_phi) - (DataW+1)'(qpos);
      width <= (DataW+1)'(rd_phi) - (DataW+1)'(rd_plo);
    end
    if (cmd.mul_a) prod_a <= mul_res;
    if (cmd.mul_b) prod_b <= mul_res;
    if (cmd.sum) begin
      num <= (2*DataW+2)'(prod_a) + (2*DataW+2)'(prod_b);
      dvs <= width[DataW] ? (DataW+1)'(0) - width : width;
    end
    if (cmd.div_init) begin
      mag_hi <= num_mag[2*DataW:QuoW];
      neg    <= num[2*DataW+1] ^ width[DataW];
      rem    <= num_mag[2*DataW:QuoW];
      low    <= num_mag[QuoW-1:0];
      quo    <= '0;
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= (DataW+1)'(rem_sh - {1'b0, dvs});
        quo <= {quo[QuoW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DataW:0];
        quo <= {quo[QuoW-2:0], 1'b0};
      end
      low <= {low[QuoW-2:0], 1'b0};
    end
  end

  // overflow when the upper part is already no smaller than the divisor
  assign big = (mag_hi >= dvs);

  always_comb begin
    if (neg) begin
      if (big || quo > 32'h8000_0000) res = 32'sh8000_0000;
      else                            res = DataW'(-quo);
    end else begin
      if (big || quo > 32'h7FFF_FFFF) res = 32'sh7FFF_FFFF;
      else                            res = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value   <= (width == '0) ? '0 : res;
      out_segment <= io;
      out_oor     <= !found;
      out_zw      <= (width == '0);
    end
  end

endmodule

[src/linear_interp_resample_1d_top.sv]
// Top level: piecewise linear interpolation resampler over a loaded knot table.
// A request with func 0 writes one knot (position, value) into the 1024-entry tables and
// gives no response. A request with func 1 is a query: the block searches forward from the
// last segment used (segment 0 when new_sweep is set), each segment tried passing through a
// read state and a check state since the knot tables are read through registered ports,
// then fetches, forms differences, multiplies (one shared 32x33 multiplier, two passes) and
// sums, and runs a restoring divider giving one quotient bit per cycle. A query holds the
// block from its acceptance until its response is loaded, the response turning valid as the
// block returns to idle to accept the next request; a still waiting earlier response adds
// its stall. An ordered sweep usually tries one or two segments. One request is worked on at
// a time; the response sits in an output register so the next request is taken while it
// waits.
// The user must write knot_count only when idle; the block itself does not enforce it.
module linear_interp_resample_1d_top
  import lirs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  lirs_req_if.sink          req,
  lirs_rsp_if.source        rsp,
  input  logic              cfg_we,
  input  logic [CntW-1:0]   cfg_data
);

  lirs_cmd_t       cmd;
  lirs_stat_t      stat;
  logic [CntW-1:0] knot_count;

  // knot_count register, resets to the two-knot minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      knot_count <= CntW'(2);
    end else if (cfg_we) begin
      knot_count <= cfg_data;
    end
  end

  lirs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.func),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lirs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .knot_count   (knot_count),
    .in_index     (req.knot_index),
    .in_value     (req.knot_value),
    .in_position  (req.position),
    .in_new_sweep (req.new_sweep),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .out_value    (rsp.interp_value),
    .out_segment  (rsp.segment_used),
    .out_oor      (rsp.out_of_range),
    .out_zw       (rsp.zero_width)
  );

endmodule

[src/lirs_checker.sv]
// Checker: port-level assertions on the resampler, bound to the top level.
module lirs_port_checks
  import lirs_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input logic signed [DataW-1:0] rsp_value,
  input logic [IdxW-1:0]         rsp_segment,
  input logic                    rsp_zw
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
    else $error("response dropped or changed while stalled");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_zw |-> rsp_value == '0)
    else $error("zero-width segment gave non-zero value");

  a_seg: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_segment != IdxW'(MaxKnots - 1))
    else $error("segment index beyond last segment");

  a_rst: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind linear_interp_resample_1d_top lirs_port_checks u_lirs_port_checks (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_value   (rsp.interp_value),
  .rsp_segment (rsp.segment_used),
  .rsp_zw      (rsp.zero_width)
);
